### rtl/json_byte_tokenizer_unit_assert.svh
// Assertion macros for the JSON byte tokenizer.
// Used by the top level only; no other dependencies.
`ifndef JSON_BYTE_TOKENIZER_UNIT_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define JBT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jbt: implication check failed");

// Next-cycle implication, checked on the rising edge outside reset.
`define JBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jbt: next-cycle check failed");

`endif

### rtl/jbt_pkg.sv
// Shared types and constants for the JSON byte tokenizer.
// No dependencies; imported by every module of the block.
package jbt_pkg;

    localparam int KIND_BITS = 4;
    localparam int BYTE_BITS = 8;
    localparam int LINE_BITS = 16;
    localparam int MAX_RES   = 3;
    localparam int CNT_BITS  = 2;

    // Scan modes
    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_STR   = 3'd1,
        M_MINUS = 3'd2,
        M_INT   = 3'd3,
        M_DOT   = 3'd4,
        M_FRAC  = 3'd5
    } t_mode;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_LBRACE = 4'd0;
    localparam logic [KIND_BITS-1:0] K_RBRACE = 4'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACK = 4'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACK = 4'd3;
    localparam logic [KIND_BITS-1:0] K_COMMA  = 4'd4;
    localparam logic [KIND_BITS-1:0] K_COLON  = 4'd5;
    localparam logic [KIND_BITS-1:0] K_STR    = 4'd6;
    localparam logic [KIND_BITS-1:0] K_INT    = 4'd7;
    localparam logic [KIND_BITS-1:0] K_FLT    = 4'd8;
    localparam logic [KIND_BITS-1:0] K_UNK    = 4'd9;
    localparam logic [KIND_BITS-1:0] K_UNT    = 4'd10;

    // Characters of interest
    localparam logic [BYTE_BITS-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_BITS-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_BITS-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_BITS-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_BITS-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_BITS-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;

    localparam logic [LINE_BITS-1:0] LINE_FIRST = 16'd1;
    localparam logic [LINE_BITS-1:0] LINE_TOP   = 16'hFFFF;

    // Scanner to emitter: load strobe and number of results in the burst
    typedef struct packed {
        logic                load;
        logic [CNT_BITS-1:0] count;
    } t_scan_ctl;

endpackage

### rtl/jbt_if.sv
// Stream interfaces of the JSON byte tokenizer: text bytes in, tokens out.
// Depends on jbt_pkg for field widths.
interface jbt_byte_if
    import jbt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] text_byte;
    logic                 final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface jbt_token_if
    import jbt_pkg::*;
#(
    parameter int POS_BITS = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] token_kind;
    logic [POS_BITS-1:0]  begin_pos;
    logic [POS_BITS:0]    finish_pos;
    logic [LINE_BITS-1:0] line_number;
    logic [BYTE_BITS-1:0] odd_byte;
    logic                 run_end;

    modport source (
        output valid, output token_kind, output begin_pos, output finish_pos,
        output line_number, output odd_byte, output run_end, input ready
    );
    modport sink (
        input valid, input token_kind, input begin_pos, input finish_pos,
        input line_number, input odd_byte, input run_end, output ready
    );
endinterface

### rtl/json_byte_tokenizer_unit.sv
// JSON byte tokenizer: one text byte per transfer in, tokens (kind, start and end
// position, line, offending byte) out. While the token output is not stalled and
// each byte yields no result or one result, a steady stream runs at a byte per
// clock; a byte that yields several results (up to three, e.g. a number whose dot
// turns out dangling, followed by a punctuation mark) holds the input while the
// result register sends one token per transfer. The first token of a byte passes
// the input register, then the result register, before it is valid on the output.
// Start positions are POS_BITS wide, end positions one bit wider, and both saturate;
// the final_byte flag flushes any open token and restarts counting at position 0,
// line 1. No clearing pass after reset.
// Depends on jbt_pkg, jbt_if, jbt_scan, jbt_emit and the assertion header.
`include "json_byte_tokenizer_unit_assert.svh"

module json_byte_tokenizer_unit
    import jbt_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jbt_byte_if.sink    i_byte,
    jbt_token_if.source o_token
);

    localparam int REC_W = KIND_BITS + 2 * POS_BITS + 1 + LINE_BITS + BYTE_BITS;

    t_scan_ctl        ctl;
    logic [REC_W-1:0] recs [MAX_RES];
    logic             burst_free;

    // token stream terms for the checks
    logic             tok_plain;
    logic             tok_span_ok;
    logic             tok_mid_burst;

    // byte decode and scan state
    jbt_scan #(
        .POS_BITS (POS_BITS),
        .REC_W    (REC_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_burst_free (burst_free),
        .o_ctl        (ctl),
        .o_recs       (recs)
    );

    // result register and token sequencing
    jbt_emit #(
        .POS_BITS (POS_BITS),
        .REC_W    (REC_W)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_recs       (recs),
        .o_burst_free (burst_free),
        .o_token      (o_token)
    );

    assign tok_plain     = o_token.valid && (o_token.token_kind != K_UNK);
    assign tok_span_ok   = {1'b0, o_token.begin_pos} <= o_token.finish_pos;
    assign tok_mid_burst = o_token.valid && o_token.ready && !o_token.run_end;

    // checks on the token stream
    `JBT_ASSERT_IMPLY(a_kind_range, i_clk, i_rst_n, o_token.valid, o_token.token_kind <= K_UNT)
    `JBT_ASSERT_IMPLY(a_odd_only_unknown, i_clk, i_rst_n, tok_plain, o_token.odd_byte == '0)
    `JBT_ASSERT_IMPLY(a_span_order, i_clk, i_rst_n, o_token.valid, tok_span_ok)
    `JBT_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, tok_mid_burst, o_token.valid)

endmodule

### rtl/jbt_scan.sv
// Input register, scan state and per-byte token decode.
// Depends on jbt_pkg and jbt_byte_if; feeds jbt_emit.
module jbt_scan
    import jbt_pkg::*;
#(
    parameter int POS_BITS = 16,
    parameter int REC_W    = KIND_BITS + 2 * POS_BITS + 1 + LINE_BITS + BYTE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jbt_byte_if.sink         i_byte,
    input  logic             i_burst_free,
    output t_scan_ctl        o_ctl,
    output logic [REC_W-1:0] o_recs [MAX_RES]
);

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  begin_pos;
        logic [POS_BITS:0]    finish_pos;
        logic [LINE_BITS-1:0] line;
        logic [BYTE_BITS-1:0] odd;
    } t_rec;

    function automatic t_rec mk_rec(
        input logic [KIND_BITS-1:0] kind,
        input logic [POS_BITS-1:0]  b,
        input logic [POS_BITS:0]    f,
        input logic [LINE_BITS-1:0] ln,
        input logic [BYTE_BITS-1:0] odd
    );
        t_rec rec;
        rec.kind       = kind;
        rec.begin_pos  = b;
        rec.finish_pos = f;
        rec.line       = ln;
        rec.odd        = odd;
        return rec;
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] ln);
        return (ln == LINE_TOP) ? ln : ln + 1'b1;
    endfunction

    // input register
    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_byte;
    logic                 r_fin;

    // scan state
    t_mode                r_mode;
    logic [POS_BITS:0]    r_pos;
    logic [POS_BITS-1:0]  r_start;
    logic [LINE_BITS-1:0] r_line;

    // next state and burst
    t_mode                n_mode;
    logic [POS_BITS-1:0]  n_start;
    logic [LINE_BITS-1:0] n_line;
    logic [CNT_BITS-1:0]  cnt;
    t_rec                 recs [MAX_RES];
    logic                 consume;

    // derived positions, saturated as needed
    logic                 pos_sat;
    logic [POS_BITS-1:0]  pos_b;
    logic [POS_BITS:0]    pos_f1;
    logic [POS_BITS-1:0]  pos_b1;
    logic [POS_BITS-1:0]  dot_b;
    logic [POS_BITS:0]    dot_f;
    logic [POS_BITS:0]    dot_f1;
    logic                 is_dig;

    assign consume      = r_in_valid && i_burst_free;
    assign i_byte.ready = !r_in_valid || consume;

    assign pos_sat = r_pos[POS_BITS];
    assign pos_b   = pos_sat ? {POS_BITS{1'b1}} : r_pos[POS_BITS-1:0];
    assign pos_f1  = pos_sat ? r_pos : r_pos + {{POS_BITS{1'b0}}, 1'b1};
    assign pos_b1  = (pos_sat || (&r_pos[POS_BITS-1:0])) ? {POS_BITS{1'b1}}
                                                         : r_pos[POS_BITS-1:0] + 1'b1;
    assign dot_b   = (r_pos == '0) ? '0 : POS_BITS'(r_pos - 1'b1);
    assign dot_f   = {1'b0, dot_b};
    assign dot_f1  = (r_pos == '0) ? {{POS_BITS{1'b0}}, 1'b1} : r_pos;
    assign is_dig  = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);

    // decode one byte: pending token, fresh scan, then end of buffer
    always_comb begin
        logic do_idle;
        do_idle = 1'b0;
        n_mode  = r_mode;
        n_start = r_start;
        n_line  = r_line;
        cnt     = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            recs[k] = '0;
        end

        case (r_mode)
            M_STR: begin
                if (r_byte == CH_QUOTE) begin
                    recs[cnt] = mk_rec(K_STR, r_start, r_pos, n_line, '0);
                    cnt       = cnt + 1'b1;
                    n_mode    = M_IDLE;
                end else if (r_byte == CH_NL) begin
                    n_line = line_inc(n_line);
                end
            end
            M_MINUS: begin
                if (is_dig) begin
                    n_mode = M_INT;
                end else begin
                    recs[cnt] = mk_rec(K_UNK, r_start, {1'b0, r_start} + 1'b1, n_line,
                                       CH_MINUS);
                    cnt       = cnt + 1'b1;
                    n_mode    = M_IDLE;
                    do_idle   = 1'b1;
                end
            end
            M_INT: begin
                if (is_dig) begin
                    n_mode = M_INT;
                end else if (r_byte == CH_DOT) begin
                    n_mode = M_DOT;
                end else begin
                    recs[cnt] = mk_rec(K_INT, r_start, r_pos, n_line, '0);
                    cnt       = cnt + 1'b1;
                    n_mode    = M_IDLE;
                    do_idle   = 1'b1;
                end
            end
            M_DOT: begin
                if (is_dig) begin
                    n_mode = M_FRAC;
                end else begin
                    recs[cnt] = mk_rec(K_INT, r_start, dot_f, n_line, '0);
                    cnt       = cnt + 1'b1;
                    recs[cnt] = mk_rec(K_UNK, dot_b, dot_f1, n_line, CH_DOT);
                    cnt       = cnt + 1'b1;
                    n_mode    = M_IDLE;
                    do_idle   = 1'b1;
                end
            end
            M_FRAC: begin
                if (!is_dig) begin
                    recs[cnt] = mk_rec(K_FLT, r_start, r_pos, n_line, '0);
                    cnt       = cnt + 1'b1;
                    n_mode    = M_IDLE;
                    do_idle   = 1'b1;
                end
            end
            default: begin
                n_mode  = M_IDLE;
                do_idle = 1'b1;
            end
        endcase

        // byte scanned with nothing pending
        if (do_idle) begin
            case (r_byte)
                CH_LBRACE: begin
                    recs[cnt] = mk_rec(K_LBRACE, pos_b, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                CH_RBRACE: begin
                    recs[cnt] = mk_rec(K_RBRACE, pos_b, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                CH_LBRACK: begin
                    recs[cnt] = mk_rec(K_LBRACK, pos_b, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                CH_RBRACK: begin
                    recs[cnt] = mk_rec(K_RBRACK, pos_b, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                CH_COMMA: begin
                    recs[cnt] = mk_rec(K_COMMA, pos_b, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                CH_COLON: begin
                    recs[cnt] = mk_rec(K_COLON, pos_b, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                CH_QUOTE: begin
                    n_mode  = M_STR;
                    n_start = pos_b1;
                end
                CH_NL: begin
                    n_line = line_inc(n_line);
                end
                CH_MINUS: begin
                    n_mode  = M_MINUS;
                    n_start = pos_b;
                end
                default: begin
                    if (is_dig) begin
                        n_mode  = M_INT;
                        n_start = pos_b;
                    end else begin
                        recs[cnt] = mk_rec(K_UNK, pos_b, pos_f1, n_line, r_byte);
                        cnt       = cnt + 1'b1;
                    end
                end
            endcase
        end

        // end of buffer flushes whatever is still open
        if (r_fin) begin
            case (n_mode)
                M_STR: begin
                    recs[cnt] = mk_rec(K_UNT, n_start, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                M_MINUS: begin
                    recs[cnt] = mk_rec(K_UNK, n_start, {1'b0, n_start} + 1'b1, n_line,
                                       CH_MINUS);
                    cnt       = cnt + 1'b1;
                end
                M_INT: begin
                    recs[cnt] = mk_rec(K_INT, n_start, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                M_DOT: begin
                    recs[cnt] = mk_rec(K_INT, n_start, r_pos, n_line, '0);
                    cnt       = cnt + 1'b1;
                    recs[cnt] = mk_rec(K_UNK, pos_b, pos_f1, n_line, CH_DOT);
                    cnt       = cnt + 1'b1;
                end
                M_FRAC: begin
                    recs[cnt] = mk_rec(K_FLT, n_start, pos_f1, n_line, '0);
                    cnt       = cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ctl.load  = consume;
    assign o_ctl.count = cnt;

    for (genvar g = 0; g < MAX_RES; g++) begin : g_recs
        assign o_recs[g] = REC_W'(recs[g]);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.text_byte;
            r_fin  <= i_byte.final_byte;
        end
    end

    // scan state; end of buffer returns to the reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= LINE_FIRST;
        end else if (consume) begin
            if (r_fin) begin
                r_mode  <= M_IDLE;
                r_pos   <= '0;
                r_start <= '0;
                r_line  <= LINE_FIRST;
            end else begin
                r_mode  <= n_mode;
                r_pos   <= pos_f1;
                r_start <= n_start;
                r_line  <= n_line;
            end
        end
    end

endmodule

### rtl/jbt_emit.sv
// Result register: holds the results of one byte and sends them one per transfer.
// Depends on jbt_pkg and jbt_token_if; fed by jbt_scan.
module jbt_emit
    import jbt_pkg::*;
#(
    parameter int POS_BITS = 16,
    parameter int REC_W    = KIND_BITS + 2 * POS_BITS + 1 + LINE_BITS + BYTE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [REC_W-1:0] i_recs [MAX_RES],
    output logic             o_burst_free,
    jbt_token_if.source      o_token
);

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  begin_pos;
        logic [POS_BITS:0]    finish_pos;
        logic [LINE_BITS-1:0] line;
        logic [BYTE_BITS-1:0] odd;
    } t_rec;

    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] r_idx;
    logic [REC_W-1:0]    r_recs [MAX_RES];
    t_rec                cur;
    logic                last;
    logic                xfer;

    assign cur  = t_rec'(r_recs[r_idx]);
    assign last = (r_idx == r_cnt - 1'b1);
    assign xfer = o_token.valid && o_token.ready;

    // room for a new burst when empty or once the last result of this one goes out
    assign o_burst_free = (r_cnt == '0) || (xfer && last);

    assign o_token.valid       = (r_cnt != '0);
    assign o_token.token_kind  = cur.kind;
    assign o_token.begin_pos   = cur.begin_pos;
    assign o_token.finish_pos  = cur.finish_pos;
    assign o_token.line_number = cur.line;
    assign o_token.odd_byte    = cur.odd;
    assign o_token.run_end     = last;

    // burst count and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= i_ctl.count;
            r_idx <= '0;
        end else if (xfer) begin
            if (last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // burst payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_recs[k] <= i_recs[k];
            end
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for json_byte_tokenizer_unit: streams JSON-like text, predicts the token
// stream with a behavioral scanner and checks every token transfer in order.
// Depends on jbt_pkg and the jbt_byte_if / jbt_token_if interfaces.
module testbench;
    import jbt_pkg::*;

    localparam int POS_BITS     = 16;
    localparam int BEGIN_TOP    = (1 << POS_BITS) - 1;
    localparam int FINISH_TOP   = 1 << POS_BITS;
    localparam int MAX_GAP      = 5;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 150;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  begin_pos;
        logic [POS_BITS:0]    finish_pos;
        logic [LINE_BITS-1:0] line_number;
        logic [BYTE_BITS-1:0] odd_byte;
        logic                 run_end;
    } t_token;

    logic i_clk;
    logic i_rst_n;

    jbt_byte_if                          byte_ch ();
    jbt_token_if #(.POS_BITS(POS_BITS)) token_ch ();

    json_byte_tokenizer_unit #(
        .POS_BITS(POS_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_token (token_ch)
    );

    // Scanner model state
    t_mode                lex_mode;
    int unsigned          text_pos;
    int unsigned          tok_start;
    logic [LINE_BITS-1:0] line_cnt;

    t_token expected_tokens[$];   // tokens still owed by the block, oldest first
    t_token burst_tokens[$];      // tokens caused by the byte being scanned
    int     errors;
    bit     input_gaps;
    bit     output_stalls;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #TIMEOUT_NS;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned clip_begin(int unsigned v);
        return (v > BEGIN_TOP) ? BEGIN_TOP : v;
    endfunction

    function automatic int unsigned clip_finish(int unsigned v);
        return (v > FINISH_TOP) ? FINISH_TOP : v;
    endfunction

    function automatic bit is_digit(logic [BYTE_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [BYTE_BITS-1:0] rand_digit();
        return CH_ZERO + BYTE_BITS'($urandom_range(0, 9));
    endfunction

    function automatic void count_line();
        if (line_cnt != LINE_TOP) line_cnt++;
    endfunction

    function automatic void reset_scanner();
        lex_mode  = M_IDLE;
        text_pos  = 0;
        tok_start = 0;
        line_cnt  = LINE_FIRST;
    endfunction

    // Queue one token of the current byte; at most MAX_RES per byte
    function automatic void push_token(logic [KIND_BITS-1:0] kind, int unsigned b,
                                       int unsigned f, logic [BYTE_BITS-1:0] odd);
        t_token t;
        if (burst_tokens.size() >= MAX_RES) return;
        t.kind        = kind;
        t.begin_pos   = POS_BITS'(clip_begin(b));
        t.finish_pos  = (POS_BITS + 1)'(clip_finish(f));
        t.line_number = line_cnt;
        t.odd_byte    = odd;
        t.run_end     = 1'b0;
        burst_tokens.insert(burst_tokens.size(), t);
    endfunction

    // Byte seen with no token open
    function automatic void scan_fresh(logic [BYTE_BITS-1:0] c, int unsigned p);
        case (c)
            CH_LBRACE: push_token(K_LBRACE, p, p + 1, 8'h00);
            CH_RBRACE: push_token(K_RBRACE, p, p + 1, 8'h00);
            CH_LBRACK: push_token(K_LBRACK, p, p + 1, 8'h00);
            CH_RBRACK: push_token(K_RBRACK, p, p + 1, 8'h00);
            CH_COMMA:  push_token(K_COMMA, p, p + 1, 8'h00);
            CH_COLON:  push_token(K_COLON, p, p + 1, 8'h00);
            CH_QUOTE: begin
                lex_mode  = M_STR;
                tok_start = clip_begin(p + 1);
            end
            CH_NL: count_line();
            CH_MINUS: begin
                lex_mode  = M_MINUS;
                tok_start = clip_begin(p);
            end
            default: begin
                if (is_digit(c)) begin
                    lex_mode  = M_INT;
                    tok_start = clip_begin(p);
                end else begin
                    push_token(K_UNK, p, p + 1, c);
                end
            end
        endcase
    endfunction

    // Work out the tokens one accepted byte causes and queue them
    function automatic void predict_byte(logic [BYTE_BITS-1:0] c, logic fin);
        int unsigned p;
        int unsigned dot_pos;
        p       = text_pos;
        dot_pos = (p > 0) ? p - 1 : 0;
        burst_tokens.delete();

        case (lex_mode)
            M_STR: begin
                if (c == CH_QUOTE) begin
                    push_token(K_STR, tok_start, p, 8'h00);
                    lex_mode = M_IDLE;
                end else if (c == CH_NL) begin
                    count_line();
                end
            end
            M_MINUS: begin
                if (is_digit(c)) begin
                    lex_mode = M_INT;
                end else begin
                    push_token(K_UNK, tok_start, tok_start + 1, CH_MINUS);
                    lex_mode = M_IDLE;
                    scan_fresh(c, p);
                end
            end
            M_INT: begin
                if (c == CH_DOT) begin
                    lex_mode = M_DOT;
                end else if (!is_digit(c)) begin
                    push_token(K_INT, tok_start, p, 8'h00);
                    lex_mode = M_IDLE;
                    scan_fresh(c, p);
                end
            end
            M_DOT: begin
                if (is_digit(c)) begin
                    lex_mode = M_FRAC;
                end else begin
                    // dangling dot: number ends before it, dot itself is unknown
                    push_token(K_INT, tok_start, dot_pos, 8'h00);
                    push_token(K_UNK, dot_pos, dot_pos + 1, CH_DOT);
                    lex_mode = M_IDLE;
                    scan_fresh(c, p);
                end
            end
            M_FRAC: begin
                if (!is_digit(c)) begin
                    push_token(K_FLT, tok_start, p, 8'h00);
                    lex_mode = M_IDLE;
                    scan_fresh(c, p);
                end
            end
            default: begin
                lex_mode = M_IDLE;
                scan_fresh(c, p);
            end
        endcase

        // End of buffer flushes whatever is open, then restarts at position 0, line 1
        if (fin) begin
            case (lex_mode)
                M_STR:   push_token(K_UNT, tok_start, p + 1, 8'h00);
                M_MINUS: push_token(K_UNK, tok_start, tok_start + 1, CH_MINUS);
                M_INT:   push_token(K_INT, tok_start, p + 1, 8'h00);
                M_DOT: begin
                    push_token(K_INT, tok_start, p, 8'h00);
                    push_token(K_UNK, p, p + 1, CH_DOT);
                end
                M_FRAC:  push_token(K_FLT, tok_start, p + 1, 8'h00);
                default: ;
            endcase
            reset_scanner();
        end else begin
            text_pos = clip_finish(p + 1);
        end

        if (burst_tokens.size() > 0) begin
            burst_tokens[burst_tokens.size() - 1].run_end = 1'b1;
        end
        foreach (burst_tokens[i]) expected_tokens.insert(expected_tokens.size(), burst_tokens[i]);
    endfunction

    // One byte transfer; valid stays high when the next byte follows with no gap
    task automatic send_byte(input logic [BYTE_BITS-1:0] c, input logic fin);
        int gap;
        gap = input_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.text_byte  <= c;
        byte_ch.final_byte <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        predict_byte(c, fin);
    endtask

    task automatic send_text(input string s, input logic fin_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], fin_last && (i == s.len() - 1));
        end
    endtask

    // Hold off the input until every owed token has come out
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_punctuation_and_unknown();
        send_text("{}[],:", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_pending_minus();
        send_text("-x", 1'b0);
        send_text("-5", 1'b1);
    endtask

    task automatic test_pending_dot();
        send_text("1.5]", 1'b0);
        send_text("7.}", 1'b0);
    endtask

    task automatic test_strings();
        send_text("\"a\nb\"", 1'b0);
    endtask

    task automatic test_end_of_buffer();
        send_text("-", 1'b1);
        send_text("3.", 1'b1);
        send_text("\"q", 1'b1);
    endtask

    // Mostly well-formed fragments with random content, some noise and cut-off buffers
    task automatic test_random_text();
        logic [BYTE_BITS-1:0] frag[$];
        logic [BYTE_BITS-1:0] c;
        int                   sent;
        int                   n;
        logic                 fin;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            frag.delete();
            // a stretch with no idling on either side
            input_gaps    = !(sent >= 60 && sent < 100);
            output_stalls = input_gaps;
            case ($urandom_range(0, 9))
                0, 1: begin
                    case ($urandom_range(0, 5))
                        0:       c = CH_LBRACE;
                        1:       c = CH_RBRACE;
                        2:       c = CH_LBRACK;
                        3:       c = CH_RBRACK;
                        4:       c = CH_COMMA;
                        default: c = CH_COLON;
                    endcase
                    frag.insert(frag.size(), c);
                end
                2, 3, 4: begin
                    if ($urandom_range(0, 2) == 0) frag.insert(frag.size(), CH_MINUS);
                    n = $urandom_range(1, 3);
                    repeat (n) frag.insert(frag.size(), rand_digit());
                    if ($urandom_range(0, 2) == 0) begin
                        frag.insert(frag.size(), CH_DOT);
                        n = $urandom_range(0, 2);
                        repeat (n) frag.insert(frag.size(), rand_digit());
                    end
                end
                5, 6: begin
                    frag.insert(frag.size(), CH_QUOTE);
                    n = $urandom_range(0, 4);
                    repeat (n) begin
                        c = BYTE_BITS'($urandom_range(0, 255));
                        frag.insert(frag.size(), (c == CH_QUOTE) ? CH_NL : c);
                    end
                    if ($urandom_range(0, 7) != 0) frag.insert(frag.size(), CH_QUOTE);
                end
                7: frag.insert(frag.size(), CH_NL);
                default: begin
                    n = $urandom_range(1, 2);
                    repeat (n) frag.insert(frag.size(), BYTE_BITS'($urandom_range(0, 255)));
                end
            endcase
            foreach (frag[i]) begin
                sent++;
                fin = (sent >= RANDOM_ITEMS && i == frag.size() - 1) ||
                      ($urandom_range(0, 15) == 0);
                send_byte(frag[i], fin);
            end
        end
        input_gaps    = 1'b1;
        output_stalls = 1'b1;
    endtask

    // Token sink: random stall before each transfer while output_stalls is set
    initial begin
        int stall;
        token_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = output_stalls ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                token_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            token_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!token_ch.valid);
        end
    end

    function automatic void check_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
            errors++;
        end
    endfunction

    // Compare each token transfer with the oldest owed token
    always @(posedge i_clk) begin : check_token
        t_token exp_tok;
        if (i_rst_n && token_ch.valid && token_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, kind %0d begin %0d finish %0d", $time,
                         token_ch.token_kind, token_ch.begin_pos, token_ch.finish_pos);
                errors++;
            end else begin
                exp_tok = expected_tokens.pop_front();
                check_field("token_kind", 32'(exp_tok.kind), 32'(token_ch.token_kind));
                check_field("begin_pos", 32'(exp_tok.begin_pos), 32'(token_ch.begin_pos));
                check_field("finish_pos", 32'(exp_tok.finish_pos), 32'(token_ch.finish_pos));
                check_field("line_number", 32'(exp_tok.line_number),
                            32'(token_ch.line_number));
                check_field("odd_byte", 32'(exp_tok.odd_byte), 32'(token_ch.odd_byte));
                check_field("run_end", 32'(exp_tok.run_end), 32'(token_ch.run_end));
            end
        end
    end

    // Test sequence
    initial begin
        errors             = 0;
        input_gaps         = 1'b1;
        output_stalls      = 1'b1;
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.text_byte  = '0;
        byte_ch.final_byte = 1'b0;
        reset_scanner();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_punctuation_and_unknown();
        test_pending_minus();
        wait_idle();
        test_pending_dot();
        test_strings();
        test_end_of_buffer();
        wait_idle();
        test_random_text();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/jbt_pkg.sv
rtl/jbt_if.sv
rtl/jbt_scan.sv
rtl/jbt_emit.sv
rtl/json_byte_tokenizer_unit.sv
sim/testbench.sv
